>>> rtl/fts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Shared codes for the fifo thread scheduler: actions and error codes.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int unsigned ACT_W     = 3;
  localparam int unsigned OBJ_W     = 3;
  localparam int unsigned TID_OUT_W = 4;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned OBJ_CODES = 8;
  localparam int unsigned NT_CODES  = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_FORK      = 3'd0,
    ACT_YIELD     = 3'd1,
    ACT_FINISH    = 3'd2,
    ACT_LOCK      = 3'd3,
    ACT_UNLOCK    = 3'd4,
    ACT_WAIT      = 3'd5,
    ACT_SIGNAL    = 3'd6,
    ACT_BROADCAST = 3'd7
  } action_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_NOT_OWNER   = 2'd1,
    ERR_NO_RUNNABLE = 2'd2,
    ERR_NO_CURRENT  = 2'd3
  } err_e;

endpackage

>>> rtl/fifo_thread_scheduler_with_mutex_condvar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_thread_scheduler_with_mutex_condvar_core
// Thread id scheduler: fifo ready queue, per-mutex and per-condition fifo wait
// queues kept as linked lists through a shared next-link memory.
// ----------------------------------------------------------------------------
// path: an action word is taken into the input stage and processed from there into
//   the result register; a result not yet accepted holds the input stage
// throughput: one action word per cycle while results are accepted; the next-link
//   memory has two registered read ports, fetched while the word enters the input stage
// reset: queues empty, mutexes free, thread 0 running; next-link memory is
//   not cleared, each entry is written before the lists can reach it

module fifo_thread_scheduler_with_mutex_condvar_core #(
  parameter int unsigned THREADS    = 16,
  parameter int unsigned MUTEXES    = 8,
  parameter int unsigned CONDITIONS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // action channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fts_pkg::ACT_W-1:0]        action_i,
  input  logic [fts_pkg::OBJ_W-1:0]        object_index_i,
  input  logic [fts_pkg::TID_OUT_W-1:0]    new_thread_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fts_pkg::TID_OUT_W-1:0]    running_thread_o,
  output logic                             running_valid_o,
  output logic                             switched_o,
  output logic                             lock_acquired_o,
  output logic [fts_pkg::TID_OUT_W-1:0]    woken_thread_o,
  output logic                             woken_valid_o,
  output logic [fts_pkg::ERR_W-1:0]        error_code_o
);

  localparam int unsigned TID_W = $clog2(THREADS);
  localparam int unsigned MI_W  = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
  localparam int unsigned CI_W  = (CONDITIONS > 1) ? $clog2(CONDITIONS) : 1;

  // --------------------------------------------------------------------------
  // constant reduction tables: object number onto mutex / condition, thread id
  // --------------------------------------------------------------------------
  logic [MI_W-1:0]  mi_tbl [fts_pkg::OBJ_CODES];
  logic [CI_W-1:0]  ci_tbl [fts_pkg::OBJ_CODES];
  logic [TID_W-1:0] nt_tbl [fts_pkg::NT_CODES];

  for (genvar k = 0; k < fts_pkg::OBJ_CODES; k++) begin : g_obj_tbl
    assign mi_tbl[k] = MI_W'(k % MUTEXES);
    assign ci_tbl[k] = CI_W'(k % CONDITIONS);
  end

  for (genvar k = 0; k < fts_pkg::NT_CODES; k++) begin : g_nt_tbl
    assign nt_tbl[k] = TID_W'(k % THREADS);
  end

  // --------------------------------------------------------------------------
  // scheduler state
  // --------------------------------------------------------------------------
  logic [TID_W-1:0] rh_q, rt_q, cur_q;
  logic             rne_q, pres_q;

  logic [TID_W-1:0] m_head_q  [MUTEXES];
  logic [TID_W-1:0] m_tail_q  [MUTEXES];
  logic [TID_W-1:0] m_owner_q [MUTEXES];
  logic [MUTEXES-1:0] m_ne_q, m_held_q;

  logic [TID_W-1:0] c_head_q [CONDITIONS];
  logic [TID_W-1:0] c_tail_q [CONDITIONS];
  logic [CONDITIONS-1:0] c_ne_q;

  // shared next-link store, one entry per thread id
  logic [TID_W-1:0] link_mem [THREADS];

  // --------------------------------------------------------------------------
  // input stage: the word plus its mutex / condition entry and prefetched links
  // --------------------------------------------------------------------------
  logic                 in_valid_q;
  fts_pkg::action_e     act_q;
  logic [MI_W-1:0]      mi_q;
  logic [CI_W-1:0]      ci_q;
  logic [TID_W-1:0]     nt_q;
  logic [TID_W-1:0]     mh_q, mt_q, mown_q, ch_q, ct_q;
  logic                 mne_q, mheld_q, cne_q;
  logic [TID_W-1:0]     link_a_q;  // link of the ready head
  logic [TID_W-1:0]     link_b_q;  // link of the mutex or condition head

  // result register
  logic                           out_valid_q;
  logic [fts_pkg::TID_OUT_W-1:0]  run_thread_q, woken_thread_q;
  logic                           run_valid_q, switched_q, acquired_q, woken_valid_q;
  fts_pkg::err_e                  err_q;

  logic proc, in_accept;

  assign proc       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | proc;
  assign in_accept  = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // action logic for the word in the input stage
  // --------------------------------------------------------------------------
  logic [TID_W-1:0] rh_d, rt_d, cur_d;
  logic             rne_d, pres_d;
  logic [TID_W-1:0] mh_d, mt_d, mown_d, ch_d, ct_d;
  logic             mne_d, mheld_d, cne_d;
  logic             wr_en;
  logic [TID_W-1:0] wr_addr, wr_data;
  logic             disp, acq, wv;
  logic [TID_W-1:0] woken;
  fts_pkg::err_e    err;

  always_comb begin
    rh_d    = rh_q;
    rt_d    = rt_q;
    rne_d   = rne_q;
    cur_d   = cur_q;
    pres_d  = pres_q;
    mh_d    = mh_q;
    mt_d    = mt_q;
    mne_d   = mne_q;
    mown_d  = mown_q;
    mheld_d = mheld_q;
    ch_d    = ch_q;
    ct_d    = ct_q;
    cne_d   = cne_q;
    wr_en   = 1'b0;
    wr_addr = rt_q;
    wr_data = cur_q;
    disp    = 1'b0;
    acq     = 1'b0;
    wv      = 1'b0;
    woken   = '0;
    err     = fts_pkg::ERR_OK;

    case (act_q)
      fts_pkg::ACT_FORK: begin
        if (pres_q) begin
          // current thread goes to the ready tail
          if (rne_q) begin
            wr_en   = 1'b1;
            wr_addr = rt_q;
            wr_data = cur_q;
          end else begin
            rh_d = cur_q;
          end
          rt_d  = cur_q;
          rne_d = 1'b1;
        end
        cur_d  = nt_q;
        pres_d = 1'b1;
      end
      fts_pkg::ACT_YIELD: begin
        if (pres_q) begin
          if (rne_q) begin
            wr_en   = 1'b1;
            wr_addr = rt_q;
            wr_data = cur_q;
          end else begin
            rh_d = cur_q;
          end
          rt_d  = cur_q;
          rne_d = 1'b1;
          disp  = 1'b1;
        end else if (rne_q) begin
          disp = 1'b1;
        end else begin
          err = fts_pkg::ERR_NO_RUNNABLE;
        end
      end
      fts_pkg::ACT_FINISH: begin
        if (!pres_q) begin
          err = fts_pkg::ERR_NO_CURRENT;
        end else begin
          disp = 1'b1;
        end
      end
      fts_pkg::ACT_LOCK: begin
        if (!pres_q) begin
          err = fts_pkg::ERR_NO_CURRENT;
        end else if (!mheld_q) begin
          mheld_d = 1'b1;
          mown_d  = cur_q;
          acq     = 1'b1;
        end else begin
          // block on the mutex wait queue
          if (mne_q) begin
            wr_en   = 1'b1;
            wr_addr = mt_q;
            wr_data = cur_q;
          end else begin
            mh_d = cur_q;
          end
          mt_d  = cur_q;
          mne_d = 1'b1;
          disp  = 1'b1;
        end
      end
      fts_pkg::ACT_UNLOCK: begin
        if (!pres_q) begin
          err = fts_pkg::ERR_NO_CURRENT;
        end else if (!mheld_q || (mown_q != cur_q)) begin
          err = fts_pkg::ERR_NOT_OWNER;
        end else if (mne_q) begin
          // hand the mutex to the first waiter and make it ready
          woken = mh_q;
          wv    = 1'b1;
          if (mh_q == mt_q) begin
            mne_d = 1'b0;
          end else begin
            mh_d = link_b_q;
          end
          mown_d = mh_q;
          if (rne_q) begin
            wr_en   = 1'b1;
            wr_addr = rt_q;
            wr_data = mh_q;
          end else begin
            rh_d = mh_q;
          end
          rt_d  = mh_q;
          rne_d = 1'b1;
        end else begin
          mheld_d = 1'b0;
          mown_d  = '0;
        end
      end
      fts_pkg::ACT_WAIT: begin
        if (!pres_q) begin
          err = fts_pkg::ERR_NO_CURRENT;
        end else begin
          if (cne_q) begin
            wr_en   = 1'b1;
            wr_addr = ct_q;
            wr_data = cur_q;
          end else begin
            ch_d = cur_q;
          end
          ct_d  = cur_q;
          cne_d = 1'b1;
          disp  = 1'b1;
        end
      end
      fts_pkg::ACT_SIGNAL: begin
        if (cne_q) begin
          woken = ch_q;
          wv    = 1'b1;
          if (ch_q == ct_q) begin
            cne_d = 1'b0;
          end else begin
            ch_d = link_b_q;
          end
          if (rne_q) begin
            wr_en   = 1'b1;
            wr_addr = rt_q;
            wr_data = ch_q;
          end else begin
            rh_d = ch_q;
          end
          rt_d  = ch_q;
          rne_d = 1'b1;
        end
      end
      fts_pkg::ACT_BROADCAST: begin
        // splice the whole condition queue onto the ready tail
        if (cne_q) begin
          if (rne_q) begin
            wr_en   = 1'b1;
            wr_addr = rt_q;
            wr_data = ch_q;
          end else begin
            rh_d = ch_q;
          end
          rt_d  = ct_q;
          rne_d = 1'b1;
          cne_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // current thread finished, blocked or yielded: take the ready head
    if (disp) begin
      if (rne_d) begin
        cur_d  = rh_d;
        pres_d = 1'b1;
        if (rh_d == rt_d) begin
          rne_d = 1'b0;
        end else begin
          // a link written by this same word wins over the prefetched one
          rh_d = (wr_en && (wr_addr == rh_d)) ? wr_data : link_a_q;
        end
      end else begin
        pres_d = 1'b0;
        cur_d  = '0;
        err    = fts_pkg::ERR_NO_RUNNABLE;
      end
    end
  end

  // --------------------------------------------------------------------------
  // fetch for the incoming word, forwarded from the word finishing now
  // --------------------------------------------------------------------------
  logic [MI_W-1:0]  mi_in;
  logic [CI_W-1:0]  ci_in;
  logic             m_hit, c_hit;
  logic [TID_W-1:0] fm_head, fm_tail, fm_owner, fc_head, fc_tail;
  logic             fm_ne, fm_held, fc_ne;
  logic [TID_W-1:0] addr_a, addr_b;

  assign mi_in = mi_tbl[object_index_i];
  assign ci_in = ci_tbl[object_index_i];
  assign m_hit = proc & (mi_in == mi_q);
  assign c_hit = proc & (ci_in == ci_q);

  assign fm_head  = m_hit ? mh_d    : m_head_q[mi_in];
  assign fm_tail  = m_hit ? mt_d    : m_tail_q[mi_in];
  assign fm_owner = m_hit ? mown_d  : m_owner_q[mi_in];
  assign fm_ne    = m_hit ? mne_d   : m_ne_q[mi_in];
  assign fm_held  = m_hit ? mheld_d : m_held_q[mi_in];
  assign fc_head  = c_hit ? ch_d    : c_head_q[ci_in];
  assign fc_tail  = c_hit ? ct_d    : c_tail_q[ci_in];
  assign fc_ne    = c_hit ? cne_d   : c_ne_q[ci_in];

  // port a follows the ready head, port b the head the word may pop
  assign addr_a = proc ? rh_d : rh_q;
  assign addr_b = (action_i == fts_pkg::ACT_UNLOCK) ? fm_head : fc_head;

  // --------------------------------------------------------------------------
  // next-link memory and input stage payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (proc && wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      link_a_q <= (proc && wr_en && (wr_addr == addr_a)) ? wr_data : link_mem[addr_a];
      link_b_q <= (proc && wr_en && (wr_addr == addr_b)) ? wr_data : link_mem[addr_b];
      act_q    <= fts_pkg::action_e'(action_i);
      mi_q     <= mi_in;
      ci_q     <= ci_in;
      nt_q     <= nt_tbl[new_thread_i];
      mh_q     <= fm_head;
      mt_q     <= fm_tail;
      mown_q   <= fm_owner;
      mne_q    <= fm_ne;
      mheld_q  <= fm_held;
      ch_q     <= fc_head;
      ct_q     <= fc_tail;
      cne_q    <= fc_ne;
    end
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rh_q        <= '0;
      rt_q        <= '0;
      rne_q       <= 1'b0;
      cur_q       <= '0;
      pres_q      <= 1'b1;
      m_ne_q      <= '0;
      m_held_q    <= '0;
      c_ne_q      <= '0;
      for (int i = 0; i < MUTEXES; i++) begin
        m_head_q[i]  <= '0;
        m_tail_q[i]  <= '0;
        m_owner_q[i] <= '0;
      end
      for (int i = 0; i < CONDITIONS; i++) begin
        c_head_q[i] <= '0;
        c_tail_q[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end

      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (proc) begin
        rh_q             <= rh_d;
        rt_q             <= rt_d;
        rne_q            <= rne_d;
        cur_q            <= cur_d;
        pres_q           <= pres_d;
        m_head_q[mi_q]   <= mh_d;
        m_tail_q[mi_q]   <= mt_d;
        m_owner_q[mi_q]  <= mown_d;
        m_ne_q[mi_q]     <= mne_d;
        m_held_q[mi_q]   <= mheld_d;
        c_head_q[ci_q]   <= ch_d;
        c_tail_q[ci_q]   <= ct_d;
        c_ne_q[ci_q]     <= cne_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [TID_W-1:0]                  run_id;
  logic [TID_W+fts_pkg::TID_OUT_W-1:0] run_ext, woken_ext;
  logic                              sw;

  assign run_id    = pres_d ? cur_d : '0;
  assign run_ext   = {{fts_pkg::TID_OUT_W{1'b0}}, run_id};
  assign woken_ext = {{fts_pkg::TID_OUT_W{1'b0}}, woken};
  assign sw        = (pres_q != pres_d) | (pres_d & (cur_q != cur_d));

  always_ff @(posedge clk_i) begin
    if (proc) begin
      run_thread_q   <= run_ext[fts_pkg::TID_OUT_W-1:0];
      run_valid_q    <= pres_d;
      switched_q     <= sw;
      acquired_q     <= acq;
      woken_thread_q <= woken_ext[fts_pkg::TID_OUT_W-1:0];
      woken_valid_q  <= wv;
      err_q          <= err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign running_thread_o = run_thread_q;
  assign running_valid_o  = run_valid_q;
  assign switched_o       = switched_q;
  assign lock_acquired_o  = acquired_q;
  assign woken_thread_o   = woken_thread_q;
  assign woken_valid_o    = woken_valid_q;
  assign error_code_o     = err_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a finished word always lands in the result register
  a_proc_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed word did not reach the result register");

  // a handoff or wake never comes with an error
  a_woken_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && woken_valid_o) |-> (error_code_o == fts_pkg::ERR_OK))
    else $error("woken thread reported together with an error");

  // taking a free mutex never switches threads
  a_lock_no_switch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lock_acquired_o) |-> (running_valid_o && !switched_o))
    else $error("immediate lock changed the running thread");

  // no current thread reads as id zero
  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_valid_o) |-> (running_thread_o == '0))
    else $error("running thread id set with no current thread");

endmodule
